// File: rtl/mft_pkg.sv
package mft_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int MAC_W             = 48;
  localparam int IDX_W             = 32;
  localparam int TYPE_W            = 8;
  localparam int STATUS_W          = 2;
  localparam int PCOUNT_W          = 9;

  localparam logic [TYPE_W-1:0]   STATIC_TYPE = TYPE_W'(5);
  localparam logic [PCOUNT_W-1:0] PCOUNT_MAX  = '1;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_PORT   = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE = 2'd0,
    STAT_DUP  = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [IDX_W-1:0]  ifx;
    logic [TYPE_W-1:0] typ;
  } entry_t;

endpackage

// File: rtl/mft_req_if.sv
interface mft_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  req_type;
  logic [mft_pkg::MAC_W-1:0]   mac_addr;
  logic [mft_pkg::IDX_W-1:0]   iface_idx;
  logic [mft_pkg::TYPE_W-1:0]  entry_type;

  modport source (output valid, req_type, mac_addr, iface_idx, entry_type, input ready);
  modport sink   (input valid, req_type, mac_addr, iface_idx, entry_type, output ready);
endinterface

// File: rtl/mft_rsp_if.sv
interface mft_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [mft_pkg::STATUS_W-1:0]  status;
  logic                          found;
  logic [mft_pkg::IDX_W-1:0]     found_if_index;
  logic                          is_static;
  logic [mft_pkg::PCOUNT_W-1:0]  port_mac_count;
  logic                          single_mac;
  logic [mft_pkg::MAC_W-1:0]     single_mac_addr;

  modport source (output valid, status, found, found_if_index, is_static, port_mac_count,
                  single_mac, single_mac_addr, input ready);
  modport sink   (input valid, status, found, found_if_index, is_static, port_mac_count,
                  single_mac, single_mac_addr, output ready);
endinterface

// File: rtl/mft_ram.sv
module mft_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 256,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [WIDTH-1:0]      wdata,
  input  logic [AW-1:0]         raddr,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/mac_forwarding_table_top.sv
// MAC forwarding table.
// in_req carries one request per transaction: clear, insert, look up a MAC or
// query a port. out_rsp returns exactly one result transaction per request, in
// request order. Both channels use valid/ready; a transaction moves on a rising
// clk edge with valid and ready high.
// Entries live in one RAM of TABLE_ENTRIES rows, read one row per cycle by
// MAC and interface comparators under a small sequencer. Insert, lookup and port query
// scan the valid rows in store order; insert and lookup stop at the first MAC
// match. Clear skips the scan and goes straight to the result.
// in_req.ready is high only while the sequencer is idle, one request at a time.
// The result sits in an output register; while out_rsp is stalled the block
// still takes the next request and works on it, and holds its finished result
// until the output register frees up.
// Synchronous active-low reset empties the table (entry count zero) and drops
// any pending result; the RAM contents are not cleared.
module mac_forwarding_table_top #(
  parameter int TABLE_ENTRIES = mft_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mft_req_if.sink     in_req,
  mft_rsp_if.source   out_rsp
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] entry_count_r, entry_count_nxt;
  logic [CW-1:0] iss_cnt_r, iss_cnt_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic          hit_r, hit_nxt;

  mft_pkg::req_t               req_r, req_nxt;
  logic [mft_pkg::MAC_W-1:0]   req_mac_r, req_mac_nxt;
  logic [mft_pkg::IDX_W-1:0]   req_if_r, req_if_nxt;
  logic [mft_pkg::TYPE_W-1:0]  req_typ_r, req_typ_nxt;
  logic [mft_pkg::IDX_W-1:0]   hit_if_r, hit_if_nxt;
  logic [mft_pkg::TYPE_W-1:0]  hit_typ_r, hit_typ_nxt;
  logic [mft_pkg::PCOUNT_W-1:0] pcnt_r, pcnt_nxt;
  logic [mft_pkg::MAC_W-1:0]   first_mac_r, first_mac_nxt;

  mft_pkg::status_t             res_status_r, res_status_nxt;
  logic                         res_found_r, res_found_nxt;
  logic [mft_pkg::IDX_W-1:0]    res_if_r, res_if_nxt;
  logic                         res_static_r, res_static_nxt;
  logic [mft_pkg::PCOUNT_W-1:0] res_pcnt_r, res_pcnt_nxt;
  logic                         res_single_r, res_single_nxt;
  logic [mft_pkg::MAC_W-1:0]    res_smac_r, res_smac_nxt;

  logic                         out_valid_r, out_valid_nxt;
  mft_pkg::status_t             out_status_r, out_status_nxt;
  logic                         out_found_r, out_found_nxt;
  logic [mft_pkg::IDX_W-1:0]    out_if_r, out_if_nxt;
  logic                         out_static_r, out_static_nxt;
  logic [mft_pkg::PCOUNT_W-1:0] out_pcnt_r, out_pcnt_nxt;
  logic                         out_single_r, out_single_nxt;
  logic [mft_pkg::MAC_W-1:0]    out_smac_r, out_smac_nxt;

  logic            in_xact;
  logic            out_free;
  logic            issue;
  logic            mac_req;
  logic            mac_hit;
  logic            if_hit;
  logic            ram_we;
  mft_pkg::entry_t wr_entry;
  mft_pkg::entry_t rd_entry;

  assign in_req.ready = (state_r == S_IDLE);
  assign in_xact      = in_req.valid && in_req.ready;
  assign out_free     = !out_valid_r || out_rsp.ready;
  assign issue        = (state_r == S_SCAN) && (iss_cnt_r < entry_count_r);
  assign mac_req      = (req_r == mft_pkg::REQ_INSERT) || (req_r == mft_pkg::REQ_LOOKUP);
  assign mac_hit      = (rd_entry.mac == req_mac_r);
  assign if_hit       = (rd_entry.ifx == req_if_r);
  assign ram_we       = (state_r == S_FIN) && (req_r == mft_pkg::REQ_INSERT) && !hit_r &&
                        (entry_count_r != FULL_COUNT);

  assign wr_entry.mac = req_mac_r;
  assign wr_entry.ifx = req_if_r;
  assign wr_entry.typ = req_typ_r;

  mft_ram #(
    .WIDTH ($bits(mft_pkg::entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (entry_count_r[AW-1:0]),
    .wdata (wr_entry),
    .raddr (iss_cnt_r[AW-1:0]),
    .rdata (rd_entry)
  );

  always_comb begin
    state_nxt       = state_r;
    entry_count_nxt = entry_count_r;
    iss_cnt_nxt     = iss_cnt_r;
    rd_vld_nxt      = issue;
    hit_nxt         = hit_r;
    req_nxt         = req_r;
    req_mac_nxt     = req_mac_r;
    req_if_nxt      = req_if_r;
    req_typ_nxt     = req_typ_r;
    hit_if_nxt      = hit_if_r;
    hit_typ_nxt     = hit_typ_r;
    pcnt_nxt        = pcnt_r;
    first_mac_nxt   = first_mac_r;
    res_status_nxt  = res_status_r;
    res_found_nxt   = res_found_r;
    res_if_nxt      = res_if_r;
    res_static_nxt  = res_static_r;
    res_pcnt_nxt    = res_pcnt_r;
    res_single_nxt  = res_single_r;
    res_smac_nxt    = res_smac_r;
    out_valid_nxt   = out_valid_r && !out_rsp.ready;
    out_status_nxt  = out_status_r;
    out_found_nxt   = out_found_r;
    out_if_nxt      = out_if_r;
    out_static_nxt  = out_static_r;
    out_pcnt_nxt    = out_pcnt_r;
    out_single_nxt  = out_single_r;
    out_smac_nxt    = out_smac_r;

    case (state_r)
      S_IDLE: begin
        if (in_xact) begin
          req_nxt        = mft_pkg::req_t'(in_req.req_type);
          req_mac_nxt    = in_req.mac_addr;
          req_if_nxt     = in_req.iface_idx;
          req_typ_nxt    = in_req.entry_type;
          iss_cnt_nxt    = '0;
          hit_nxt        = 1'b0;
          pcnt_nxt       = '0;
          first_mac_nxt  = '0;
          res_status_nxt = mft_pkg::STAT_DONE;
          res_found_nxt  = 1'b0;
          res_if_nxt     = '0;
          res_static_nxt = 1'b0;
          res_pcnt_nxt   = '0;
          res_single_nxt = 1'b0;
          res_smac_nxt   = '0;
          if (mft_pkg::req_t'(in_req.req_type) == mft_pkg::REQ_CLEAR) begin
            entry_count_nxt = '0;
            state_nxt       = S_RESP;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        iss_cnt_nxt = iss_cnt_r + CW'(issue);
        if (rd_vld_r && mac_req && mac_hit) begin
          hit_nxt     = 1'b1;
          hit_if_nxt  = rd_entry.ifx;
          hit_typ_nxt = rd_entry.typ;
          state_nxt   = S_FIN;
        end else begin
          if (rd_vld_r && (req_r == mft_pkg::REQ_PORT) && if_hit) begin
            if (pcnt_r == '0) begin
              first_mac_nxt = rd_entry.mac;
            end
            if (pcnt_r != mft_pkg::PCOUNT_MAX) begin
              pcnt_nxt = pcnt_r + 1'b1;
            end
          end
          if (!issue && !rd_vld_r) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        case (req_r)
          mft_pkg::REQ_INSERT: begin
            if (hit_r) begin
              res_status_nxt = mft_pkg::STAT_DUP;
            end else if (entry_count_r == FULL_COUNT) begin
              res_status_nxt = mft_pkg::STAT_FULL;
            end else begin
              entry_count_nxt = entry_count_r + 1'b1;
            end
          end
          mft_pkg::REQ_LOOKUP: begin
            res_found_nxt  = hit_r;
            res_if_nxt     = hit_r ? hit_if_r : '0;
            res_static_nxt = hit_r && (hit_typ_r == mft_pkg::STATIC_TYPE);
          end
          mft_pkg::REQ_PORT: begin
            res_pcnt_nxt   = pcnt_r;
            res_single_nxt = (pcnt_r == mft_pkg::PCOUNT_W'(1));
            res_smac_nxt   = (pcnt_r == mft_pkg::PCOUNT_W'(1)) ? first_mac_r : '0;
          end
          default: begin
          end
        endcase
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_found_nxt  = res_found_r;
          out_if_nxt     = res_if_r;
          out_static_nxt = res_static_r;
          out_pcnt_nxt   = res_pcnt_r;
          out_single_nxt = res_single_r;
          out_smac_nxt   = res_smac_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      entry_count_r <= '0;
      iss_cnt_r     <= '0;
      rd_vld_r      <= 1'b0;
      hit_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      entry_count_r <= entry_count_nxt;
      iss_cnt_r     <= iss_cnt_nxt;
      rd_vld_r      <= rd_vld_nxt;
      hit_r         <= hit_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    req_r        <= req_nxt;
    req_mac_r    <= req_mac_nxt;
    req_if_r     <= req_if_nxt;
    req_typ_r    <= req_typ_nxt;
    hit_if_r     <= hit_if_nxt;
    hit_typ_r    <= hit_typ_nxt;
    pcnt_r       <= pcnt_nxt;
    first_mac_r  <= first_mac_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_if_r     <= res_if_nxt;
    res_static_r <= res_static_nxt;
    res_pcnt_r   <= res_pcnt_nxt;
    res_single_r <= res_single_nxt;
    res_smac_r   <= res_smac_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_if_r     <= out_if_nxt;
    out_static_r <= out_static_nxt;
    out_pcnt_r   <= out_pcnt_nxt;
    out_single_r <= out_single_nxt;
    out_smac_r   <= out_smac_nxt;
  end

  assign out_rsp.valid           = out_valid_r;
  assign out_rsp.status          = out_status_r;
  assign out_rsp.found           = out_found_r;
  assign out_rsp.found_if_index  = out_if_r;
  assign out_rsp.is_static       = out_static_r;
  assign out_rsp.port_mac_count  = out_pcnt_r;
  assign out_rsp.single_mac      = out_single_r;
  assign out_rsp.single_mac_addr = out_smac_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entry_count_r <= FULL_COUNT)
    else $error("entry count above table size");

  a_write_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (entry_count_r == $past(entry_count_r) + 1'b1))
    else $error("table write without count advance");

  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_xact |=> (state_r == S_SCAN || state_r == S_RESP))
    else $error("accepted transaction not started");

  a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> ($past(state_r) == S_SCAN))
    else $error("read data outside scan");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (iss_cnt_r <= entry_count_r))
    else $error("scan ran past valid entries");

endmodule
